>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL; clock and reset names are fixed by the house style.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lmjs_pkg.sv
package lmjs_pkg;

    // Mode codes
    localparam logic [2:0] MODE_NOFORCE  = 3'd0;
    localparam logic [2:0] MODE_LOW      = 3'd1;
    localparam logic [2:0] MODE_MID      = 3'd2;
    localparam logic [2:0] MODE_HIGH     = 3'd3;
    localparam logic [2:0] MODE_SPIN     = 3'd4;
    localparam logic [2:0] MODE_RETRACT1 = 3'd5;
    localparam logic [2:0] MODE_EXTEND   = 3'd6;
    localparam logic [2:0] MODE_RETRACT2 = 3'd7;

    // Leg height request codes
    localparam logic [1:0] LEG_MID  = 2'd1;
    localparam logic [1:0] LEG_HIGH = 2'd2;

    // Jump phase codes
    localparam logic [1:0] PHASE_NONE     = 2'd0;
    localparam logic [1:0] PHASE_RETRACT1 = 2'd1;
    localparam logic [1:0] PHASE_EXTEND   = 2'd2;
    localparam logic [1:0] PHASE_RETRACT2 = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_SECOND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_THRESH   = 2'd3;

    // Configuration reset values
    localparam logic [15:0]        RST_RETRACT_FIRST  = 16'd450;
    localparam logic [15:0]        RST_EXTEND_TIMEOUT = 16'd1000;
    localparam logic [15:0]        RST_RETRACT_SECOND = 16'd450;
    localparam logic signed [15:0] RST_REACH_THRESH   = 16'sd3400;

    // One control tick as held in the input register
    typedef struct packed {
        logic              tick_ok;
        logic              power_req;
        logic [1:0]        leg_mode;
        logic              spin_enable;
        logic              jump_button;
        logic signed [15:0] leg_length;
        logic [31:0]       time_ms;
    } t_tick;

    // Target leg length per mode, 0.1 mm units
    function automatic logic [11:0] target_of(input logic [2:0] mode);
        logic [11:0] len;
        case (mode)
            MODE_NOFORCE:  len = 12'd1800;
            MODE_LOW:      len = 12'd1800;
            MODE_MID:      len = 12'd2300;
            MODE_HIGH:     len = 12'd2300;
            MODE_SPIN:     len = 12'd1800;
            MODE_RETRACT1: len = 12'd1400;
            MODE_EXTEND:   len = 12'd3800;
            MODE_RETRACT2: len = 12'd2000;
            default:       len = 12'd1800;
        endcase
        return len;
    endfunction

    // Jump phase per mode
    function automatic logic [1:0] phase_of(input logic [2:0] mode);
        logic [1:0] ph;
        case (mode)
            MODE_RETRACT1: ph = PHASE_RETRACT1;
            MODE_EXTEND:   ph = PHASE_EXTEND;
            MODE_RETRACT2: ph = PHASE_RETRACT2;
            default:       ph = PHASE_NONE;
        endcase
        return ph;
    endfunction

endpackage

>>> sv/leg_mode_jump_sequencer.sv
// Leg mode and jump sequencer.
// Input channel: one control tick per beat on i_in_valid / o_in_stall; the beat is
// taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: one result per tick on o_out_valid / i_out_stall, in tick order.
// Config channel: i_cfg_valid / o_cfg_ready with register index and 16-bit data;
// o_cfg_ready is always high. Write only while no tick is in flight.
// Flow: a taken tick is held in the input register and moves into the output
// register when that register is empty or its result is taken; o_out_valid is
// the registered valid bit of the output register.
// Throughput: one tick per cycle while no result is stalled; the mode update is a
// single pass of compare and 32-bit subtract logic from input to output register.
// Stall: while i_out_stall holds a result, the input register keeps its tick and
// o_in_stall rises once it is full; the result and its fields do not change.
// Reset (synchronous, i_rst_n low): both stages empty, mode no-force, button level
// and phase start time cleared, config registers back to their defaults.
module leg_mode_jump_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_tick_ok,
    input  logic                           i_power_req,
    input  logic [1:0]                     i_leg_mode,
    input  logic                           i_spin_enable,
    input  logic                           i_jump_button,
    input  logic signed [15:0]             i_leg_length,
    input  logic [31:0]                    i_time_ms,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_mode,
    output logic                           o_mode_changed,
    output logic                           o_motor_enable,
    output logic                           o_chassis_run,
    output logic                           o_spin_active,
    output logic [11:0]                    o_target_length,
    output logic [1:0]                     o_jump_stage,
    // config channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lmjs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    `include "assert_macros.svh"

    // config registers
    logic [15:0]        r_retract_first;
    logic [15:0]        r_extend_timeout;
    logic [15:0]        r_retract_second;
    logic signed [15:0] r_reach_thresh;

    // pipeline registers
    logic               r_in_vld;
    lmjs_pkg::t_tick    r_in;
    logic               r_out_vld;
    logic [2:0]         r_out_mode;
    logic               r_out_changed;

    // sequencer state
    logic [2:0]         r_mode;
    logic               r_last_btn;
    logic [31:0]        r_phase_t;

    logic [2:0]         n_mode;
    logic               n_last_btn;
    logic [31:0]        n_phase_t;
    logic               n_changed;

    logic               adv;
    logic               take;
    logic               edge_seen;
    logic [2:0]         requested;
    logic [2:0]         want;
    logic [31:0]        elapsed;

    // Move the input register into the output register when the output is free
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign take       = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !adv;
    assign o_cfg_ready = 1'b1;

    // Requested steady mode and jump edge
    assign edge_seen = r_in.jump_button && !r_last_btn;
    assign elapsed   = r_in.time_ms - r_phase_t;

    always_comb begin
        if (r_in.spin_enable) begin
            requested = lmjs_pkg::MODE_SPIN;
        end else if (r_in.leg_mode == lmjs_pkg::LEG_MID) begin
            requested = lmjs_pkg::MODE_MID;
        end else if (r_in.leg_mode == lmjs_pkg::LEG_HIGH) begin
            requested = lmjs_pkg::MODE_HIGH;
        end else begin
            requested = lmjs_pkg::MODE_LOW;
        end
    end

    // Choose the mode this tick asks for
    always_comb begin
        want = r_mode;
        if (!r_in.tick_ok) begin
            want = lmjs_pkg::MODE_NOFORCE;
        end else if (r_mode == lmjs_pkg::MODE_NOFORCE) begin
            if (r_in.power_req) begin
                want = edge_seen ? lmjs_pkg::MODE_RETRACT1 : requested;
            end
        end else if (!r_in.power_req) begin
            want = lmjs_pkg::MODE_NOFORCE;
        end else begin
            case (r_mode)
                lmjs_pkg::MODE_RETRACT1: begin
                    if (elapsed >= {16'd0, r_retract_first}) begin
                        want = lmjs_pkg::MODE_EXTEND;
                    end
                end
                lmjs_pkg::MODE_EXTEND: begin
                    if (r_in.leg_length >= r_reach_thresh ||
                        elapsed >= {16'd0, r_extend_timeout}) begin
                        want = lmjs_pkg::MODE_RETRACT2;
                    end
                end
                lmjs_pkg::MODE_RETRACT2: begin
                    if (elapsed >= {16'd0, r_retract_second}) begin
                        want = requested;
                    end
                end
                default: begin
                    want = edge_seen ? lmjs_pkg::MODE_RETRACT1 : requested;
                end
            endcase
        end
    end

    // Next state; stamp the phase time when a jump phase is entered
    always_comb begin
        n_changed  = (want != r_mode);
        n_mode     = want;
        n_last_btn = r_in.tick_ok ? r_in.jump_button : 1'b0;
        n_phase_t  = r_phase_t;
        if (n_changed && want >= lmjs_pkg::MODE_RETRACT1) begin
            n_phase_t = r_in.time_ms;
        end
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retract_first  <= lmjs_pkg::RST_RETRACT_FIRST;
            r_extend_timeout <= lmjs_pkg::RST_EXTEND_TIMEOUT;
            r_retract_second <= lmjs_pkg::RST_RETRACT_SECOND;
            r_reach_thresh   <= lmjs_pkg::RST_REACH_THRESH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lmjs_pkg::CFG_RETRACT_FIRST:  r_retract_first  <= i_cfg_data;
                lmjs_pkg::CFG_EXTEND_TIMEOUT: r_extend_timeout <= i_cfg_data;
                lmjs_pkg::CFG_RETRACT_SECOND: r_retract_second <= i_cfg_data;
                lmjs_pkg::CFG_REACH_THRESH:   r_reach_thresh   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.tick_ok      <= i_tick_ok;
            r_in.power_req    <= i_power_req;
            r_in.leg_mode     <= i_leg_mode;
            r_in.spin_enable  <= i_spin_enable;
            r_in.jump_button  <= i_jump_button;
            r_in.leg_length   <= i_leg_length;
            r_in.time_ms      <= i_time_ms;
        end
    end

    // Sequencer state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= lmjs_pkg::MODE_NOFORCE;
            r_last_btn <= 1'b0;
            r_phase_t  <= 32'd0;
        end else if (adv) begin
            r_mode     <= n_mode;
            r_last_btn <= n_last_btn;
            r_phase_t  <= n_phase_t;
        end
    end

    // Output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_mode    <= n_mode;
            r_out_changed <= n_changed;
        end
    end

    // Decode the per-mode control table
    assign o_out_valid     = r_out_vld;
    assign o_mode          = r_out_mode;
    assign o_mode_changed  = r_out_changed;
    assign o_motor_enable  = (r_out_mode != lmjs_pkg::MODE_NOFORCE);
    assign o_chassis_run   = (r_out_mode != lmjs_pkg::MODE_NOFORCE);
    assign o_spin_active   = (r_out_mode == lmjs_pkg::MODE_SPIN);
    assign o_target_length = lmjs_pkg::target_of(r_out_mode);
    assign o_jump_stage    = lmjs_pkg::phase_of(r_out_mode);

    // Checks
    `AST_SAME(a_out_tracks_state, r_out_vld, r_out_mode == r_mode, "output mode differs from state")
    `AST_NEXT(a_invalid_noforce, adv && !r_in.tick_ok, r_mode == lmjs_pkg::MODE_NOFORCE, "not no-force")
    `AST_NEXT(a_changed_flag, adv, r_out_changed == (r_mode != $past(r_mode)), "mode_changed disagrees with mode history")
    `AST_SAME(a_stall_when_full, o_in_stall, r_in_vld && r_out_vld && i_out_stall, "input stalled without a full pipeline")

endmodule
